/* hdl/delta_list_timer_queue_top_defines.svh */
// ----------------------------------------------------------------------------
// delta list timer queue assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef DELTA_LIST_TIMER_QUEUE_TOP_DEFINES_SVH
`define DELTA_LIST_TIMER_QUEUE_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define DLTQ_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define DLTQ_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/dltq_pkg.sv */
// ----------------------------------------------------------------------------
// dltq_pkg
// shared types and constants of the delta list timer queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dltq_pkg;

   localparam int NUM_ENTRIES = 32;
   localparam int IDX_W       = $clog2(NUM_ENTRIES);
   localparam int LINK_W      = $clog2(NUM_ENTRIES + 1);
   localparam int DELTA_W     = 16;
   localparam int HANDLE_W    = 16;

   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_ENTRIES);

   typedef enum logic [1:0] {
      FUNC_TICK    = 2'd0,
      FUNC_INSERT  = 2'd1,
      FUNC_SERVICE = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      KIND_INSERTED = 3'd0,
      KIND_OVERFLOW = 3'd1,
      KIND_TICK     = 3'd2,
      KIND_EXPIRED  = 3'd3,
      KIND_NONE     = 3'd4
   } kind_type;

   typedef struct packed {
      logic [LINK_W-1:0]  link;
      logic [DELTA_W-1:0] delta;
   } node_type;

   typedef struct packed {
      logic                rd_en;
      logic [IDX_W-1:0]    rd_addr;
      logic                wr_en;
      logic [IDX_W-1:0]    wr_addr;
      node_type            wr_node;
      logic                hwr_en;
      logic [IDX_W-1:0]    hwr_addr;
      logic [HANDLE_W-1:0] hwr_data;
   } store_req_type;

   typedef struct packed {
      logic                ready;
      node_type            node;
      logic [HANDLE_W-1:0] handle;
   } store_rsp_type;

   function automatic logic link_valid(input logic [LINK_W-1:0] link);
      return link < LINK_W'(NUM_ENTRIES);
   endfunction

endpackage

`default_nettype wire

/* hdl/dltq_store.sv */
// ----------------------------------------------------------------------------
// dltq_store
// entry pool memories with a link initialization sweep after reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dltq_store
   import dltq_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire store_req_type req,
   output store_rsp_type      rsp
);

   node_type            node_mem [NUM_ENTRIES];
   logic [HANDLE_W-1:0] handle_mem [NUM_ENTRIES];

   logic [IDX_W-1:0]    init_idx_ff;
   logic                init_done_ff;
   node_type            rd_node_ff;
   logic [HANDLE_W-1:0] rd_handle_ff;

   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   node_type            wr_node;

   // free list chain: entry i links to i + 1, the last one to null
   always_comb begin
      if (!init_done_ff) begin
         wr_en         = 1'b1;
         wr_addr       = init_idx_ff;
         wr_node.link  = LINK_W'(init_idx_ff) + LINK_W'(1);
         wr_node.delta = '0;
      end else begin
         wr_en   = req.wr_en;
         wr_addr = req.wr_addr;
         wr_node = req.wr_node;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_idx_ff  <= '0;
         init_done_ff <= 1'b0;
      end else if (!init_done_ff) begin
         init_idx_ff <= init_idx_ff + IDX_W'(1);
         if (init_idx_ff == IDX_W'(NUM_ENTRIES - 1)) begin
            init_done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem[wr_addr] <= wr_node;
      end
      if (req.hwr_en) begin
         handle_mem[req.hwr_addr] <= req.hwr_data;
      end
      if (req.rd_en) begin
         rd_node_ff   <= node_mem[req.rd_addr];
         rd_handle_ff <= handle_mem[req.rd_addr];
      end
   end

   assign rsp.ready  = init_done_ff;
   assign rsp.node   = rd_node_ff;
   assign rsp.handle = rd_handle_ff;

endmodule

`default_nettype wire

/* hdl/delta_list_timer_queue_top.sv */
// ----------------------------------------------------------------------------
// delta_list_timer_queue_top
// timer queue kept as a delta list of linked entries in a memory pool
// ----------------------------------------------------------------------------
//  channel  dir  signals                       contents
//  req      in   tvalid tready tdata tuser     tdata: delay_ticks, handle
//                                              tuser: func
//  rsp      out  tvalid tready tdata tuser     tdata: expired_handle
//                tlast                         tuser: kind, tlast: last
//  csr      in   valid ready wdata             wdata: hold_expiry
//
//  busy from the accepting edge until the result is loaded, then idle for the next request
//  tick: on a nonempty list walks leading zero-delta entries, then decrements the first nonzero delta
//  insert: overflow when full, else reads entries from the head until the insert point
//  service: none when held or empty, else pops each expired entry from the head
//  after reset a sweep chains the free list, req held off
//  a result waiting in the rsp register holds emit and, once a handle is pending, each service pop
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module delta_list_timer_queue_top
   import dltq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // delay_ticks, handle
   input  wire logic [1:0]  req_tuser,   // func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // expired_handle
   output logic [2:0]       rsp_tuser,   // kind
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK,
      ST_INS_FREE,
      ST_INS_WALK,
      ST_INS_LINK,
      ST_INS_PREV,
      ST_SVC,
      ST_EMIT
   } state_type;

   state_type           state_ff, state_in;
   logic [LINK_W-1:0]   p_ff, p_in;
   logic [IDX_W-1:0]    fresh_ff, fresh_in;
   logic [LINK_W-1:0]   prev_ff, prev_in;
   logic [DELTA_W-1:0]  prev_delta_ff, prev_delta_in;
   logic [LINK_W-1:0]   next_ff, next_in;
   logic [DELTA_W-1:0]  t_ff, t_in;
   logic [LINK_W-1:0]   active_head_ff, active_head_in;
   logic [LINK_W-1:0]   free_head_ff, free_head_in;
   logic                hold_ff;
   logic                pend_ff, pend_in;
   logic [HANDLE_W-1:0] pend_handle_ff, pend_handle_in;
   kind_type            em_kind_ff, em_kind_in;
   logic [HANDLE_W-1:0] em_handle_ff, em_handle_in;
   logic                rsp_valid_ff, rsp_valid_in;
   kind_type            rsp_kind_ff, rsp_kind_in;
   logic [HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic                rsp_last_ff, rsp_last_in;

   store_req_type       sreq;
   store_rsp_type       srsp;

   logic                req_fire;
   logic                out_free;
   logic                out_load;
   kind_type            out_kind;
   logic [HANDLE_W-1:0] out_handle;
   logic                out_last;
   logic [DELTA_W-1:0]  req_delay;
   logic [HANDLE_W-1:0] req_handle;

   dltq_store u_store (
      .clock (clock),
      .reset (reset),
      .req   (sreq),
      .rsp   (srsp)
   );

   assign req_tready = (state_ff == ST_IDLE) && srsp.ready;
   assign req_fire   = req_tvalid && req_tready;
   assign req_delay  = req_tdata[15:0];
   assign req_handle = req_tdata[31:16];
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      state_in       = state_ff;
      p_in           = p_ff;
      fresh_in       = fresh_ff;
      prev_in        = prev_ff;
      prev_delta_in  = prev_delta_ff;
      next_in        = next_ff;
      t_in           = t_ff;
      active_head_in = active_head_ff;
      free_head_in   = free_head_ff;
      pend_in        = pend_ff;
      pend_handle_in = pend_handle_ff;
      em_kind_in     = em_kind_ff;
      em_handle_in   = em_handle_ff;
      out_load       = 1'b0;
      out_kind       = em_kind_ff;
      out_handle     = em_handle_ff;
      out_last       = 1'b1;
      sreq           = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               em_handle_in = '0;
               case (func_type'(req_tuser))
                  FUNC_TICK: begin
                     if (link_valid(active_head_ff)) begin
                        sreq.rd_en   = 1'b1;
                        sreq.rd_addr = active_head_ff[IDX_W-1:0];
                        p_in         = active_head_ff;
                        state_in     = ST_TICK;
                     end else begin
                        em_kind_in = KIND_TICK;
                        state_in   = ST_EMIT;
                     end
                  end
                  FUNC_INSERT: begin
                     if (link_valid(free_head_ff)) begin
                        fresh_in      = free_head_ff[IDX_W-1:0];
                        t_in          = req_delay;
                        sreq.rd_en    = 1'b1;
                        sreq.rd_addr  = free_head_ff[IDX_W-1:0];
                        sreq.hwr_en   = 1'b1;
                        sreq.hwr_addr = free_head_ff[IDX_W-1:0];
                        sreq.hwr_data = req_handle;
                        state_in      = ST_INS_FREE;
                     end else begin
                        em_kind_in = KIND_OVERFLOW;
                        state_in   = ST_EMIT;
                     end
                  end
                  FUNC_SERVICE: begin
                     if (!hold_ff && link_valid(active_head_ff)) begin
                        sreq.rd_en   = 1'b1;
                        sreq.rd_addr = active_head_ff[IDX_W-1:0];
                        p_in         = active_head_ff;
                        pend_in      = 1'b0;
                        state_in     = ST_SVC;
                     end else begin
                        em_kind_in = KIND_NONE;
                        state_in   = ST_EMIT;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_TICK: begin
            if (srsp.node.delta != '0) begin
               sreq.wr_en         = 1'b1;
               sreq.wr_addr       = p_ff[IDX_W-1:0];
               sreq.wr_node.link  = srsp.node.link;
               sreq.wr_node.delta = srsp.node.delta - DELTA_W'(1);
               em_kind_in         = KIND_TICK;
               state_in           = ST_EMIT;
            end else if (link_valid(srsp.node.link)) begin
               sreq.rd_en   = 1'b1;
               sreq.rd_addr = srsp.node.link[IDX_W-1:0];
               p_in         = srsp.node.link;
            end else begin
               em_kind_in = KIND_TICK;
               state_in   = ST_EMIT;
            end
         end

         ST_INS_FREE: begin
            free_head_in = srsp.node.link;
            prev_in      = NULL_LINK;
            if (link_valid(active_head_ff)) begin
               sreq.rd_en   = 1'b1;
               sreq.rd_addr = active_head_ff[IDX_W-1:0];
               p_in         = active_head_ff;
               state_in     = ST_INS_WALK;
            end else begin
               next_in  = NULL_LINK;
               state_in = ST_INS_LINK;
            end
         end

         ST_INS_WALK: begin
            if (srsp.node.delta < t_ff) begin
               t_in          = t_ff - srsp.node.delta;
               prev_in       = p_ff;
               prev_delta_in = srsp.node.delta;
               if (link_valid(srsp.node.link)) begin
                  sreq.rd_en   = 1'b1;
                  sreq.rd_addr = srsp.node.link[IDX_W-1:0];
                  p_in         = srsp.node.link;
               end else begin
                  next_in  = NULL_LINK;
                  state_in = ST_INS_LINK;
               end
            end else begin
               // follower keeps only what lies beyond the new entry
               sreq.wr_en         = 1'b1;
               sreq.wr_addr       = p_ff[IDX_W-1:0];
               sreq.wr_node.link  = srsp.node.link;
               sreq.wr_node.delta = srsp.node.delta - t_ff;
               next_in            = p_ff;
               state_in           = ST_INS_LINK;
            end
         end

         ST_INS_LINK: begin
            sreq.wr_en         = 1'b1;
            sreq.wr_addr       = fresh_ff;
            sreq.wr_node.link  = next_ff;
            sreq.wr_node.delta = t_ff;
            if (link_valid(prev_ff)) begin
               state_in = ST_INS_PREV;
            end else begin
               active_head_in = LINK_W'(fresh_ff);
               em_kind_in     = KIND_INSERTED;
               state_in       = ST_EMIT;
            end
         end

         ST_INS_PREV: begin
            sreq.wr_en         = 1'b1;
            sreq.wr_addr       = prev_ff[IDX_W-1:0];
            sreq.wr_node.link  = LINK_W'(fresh_ff);
            sreq.wr_node.delta = prev_delta_ff;
            em_kind_in         = KIND_INSERTED;
            state_in           = ST_EMIT;
         end

         ST_SVC: begin
            if (!(pend_ff && !out_free)) begin
               if (srsp.node.delta == '0) begin
                  // pop head back onto the free list
                  active_head_in     = srsp.node.link;
                  free_head_in       = p_ff;
                  sreq.wr_en         = 1'b1;
                  sreq.wr_addr       = p_ff[IDX_W-1:0];
                  sreq.wr_node.link  = free_head_ff;
                  sreq.wr_node.delta = srsp.node.delta;
                  if (pend_ff) begin
                     out_load   = 1'b1;
                     out_kind   = KIND_EXPIRED;
                     out_handle = pend_handle_ff;
                     out_last   = 1'b0;
                  end
                  if (link_valid(srsp.node.link)) begin
                     pend_in        = 1'b1;
                     pend_handle_in = srsp.handle;
                     sreq.rd_en     = 1'b1;
                     sreq.rd_addr   = srsp.node.link[IDX_W-1:0];
                     p_in           = srsp.node.link;
                  end else begin
                     pend_in      = 1'b0;
                     em_kind_in   = KIND_EXPIRED;
                     em_handle_in = srsp.handle;
                     state_in     = ST_EMIT;
                  end
               end else begin
                  pend_in = 1'b0;
                  if (pend_ff) begin
                     em_kind_in   = KIND_EXPIRED;
                     em_handle_in = pend_handle_ff;
                  end else begin
                     em_kind_in   = KIND_NONE;
                     em_handle_in = '0;
                  end
                  state_in = ST_EMIT;
               end
            end
         end

         ST_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = out_kind;
         rsp_handle_in = out_handle;
         rsp_last_in   = out_last;
      end else begin
         rsp_valid_in  = rsp_valid_ff && !rsp_tready;
         rsp_kind_in   = rsp_kind_ff;
         rsp_handle_in = rsp_handle_ff;
         rsp_last_in   = rsp_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         active_head_ff <= NULL_LINK;
         free_head_ff   <= '0;
         hold_ff        <= 1'b0;
         pend_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         active_head_ff <= active_head_in;
         free_head_ff   <= free_head_in;
         pend_ff        <= pend_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            hold_ff <= csr_wdata;
         end
      end
      p_ff           <= p_in;
      fresh_ff       <= fresh_in;
      prev_ff        <= prev_in;
      prev_delta_ff  <= prev_delta_in;
      next_ff        <= next_in;
      t_ff           <= t_in;
      pend_handle_ff <= pend_handle_in;
      em_kind_ff     <= em_kind_in;
      em_handle_ff   <= em_handle_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_handle_ff  <= rsp_handle_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_handle_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

/* hdl/dltq_checker.sv */
// ----------------------------------------------------------------------------
// dltq_checker
// port-level checks on the timer queue result stream
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "delta_list_timer_queue_top_defines.svh"

module dltq_checker
   import dltq_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,   // expired_handle
   input wire logic [2:0]  rsp_tuser,   // kind
   input wire logic        rsp_tlast
);

   `DLTQ_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast),
      "rsp changed while stalled")
   `DLTQ_ASSERT_IMP(a_kind_range, clock, reset, rsp_tvalid, rsp_tuser <= KIND_NONE,
      "rsp kind out of range")
   `DLTQ_ASSERT_IMP(a_handle_zero, clock, reset, rsp_tvalid && (rsp_tuser != KIND_EXPIRED),
      rsp_tdata == 16'd0, "handle set on non-expiry rsp")
   `DLTQ_ASSERT_IMP(a_single_last, clock, reset, rsp_tvalid && (rsp_tuser != KIND_EXPIRED),
      rsp_tlast, "single rsp without tlast")

endmodule

bind delta_list_timer_queue_top dltq_checker u_dltq_checker (.*);

`default_nettype wire

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// drives timer inserts, ticks and expiry service requests into the delta list
// timer queue, tracks the timer pool alongside it and checks every response
// field by field, across phases of sender idling, receiver stalls and
// hold_expiry settings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import dltq_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 2 * NUM_ENTRIES + 16;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int REPORT_MAX    = 10;

   typedef struct {
      logic [1:0]  op;
      logic [15:0] delay;
      logic [15:0] tag;
   } timer_req_type;

   typedef struct {
      kind_type    kind;
      logic [15:0] handle;
      logic        last;
   } timer_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // delay_ticks, handle
   logic [1:0]  req_tuser = '0;   // func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // expired_handle
   logic [2:0]  rsp_tuser;        // kind
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_wdata = 1'b0;

   delta_list_timer_queue_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   // timer pool as the block should hold it
   logic [15:0]       pool_delta  [NUM_ENTRIES];
   logic [15:0]       pool_handle [NUM_ENTRIES];
   logic [LINK_W-1:0] pool_link   [NUM_ENTRIES];
   logic [LINK_W-1:0] busy_head;
   logic [LINK_W-1:0] spare_head;
   logic              hold_flag;

   timer_req_type req_backlog [$];
   timer_rsp_type rsp_due [$];
   int         req_issued = 0;
   int         req_taken = 0;
   int         mismatches = 0;
   int         cycles = 0;
   int         send_idle_pct = 0;
   int         recv_stall_pct = 0;
   int         calm_left = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic due(input kind_type kind, input logic [15:0] handle, input logic last);
      timer_rsp_type r;
      r.kind = kind;
      r.handle = handle;
      r.last = last;
      rsp_due.push_back(r);
   endtask

   task automatic tick_timers();
      logic [LINK_W-1:0] p;
      int steps;
      p = busy_head;
      steps = 0;
      while (p < NUM_ENTRIES && steps < NUM_ENTRIES && pool_delta[p[IDX_W-1:0]] == 0) begin
         p = pool_link[p[IDX_W-1:0]];
         steps++;
      end
      if (p < NUM_ENTRIES && pool_delta[p[IDX_W-1:0]] > 0)
         pool_delta[p[IDX_W-1:0]] = pool_delta[p[IDX_W-1:0]] - 16'd1;
      due(KIND_TICK, 16'd0, 1'b1);
   endtask

   task automatic insert_timer(input logic [15:0] delay, input logic [15:0] tag);
      logic [LINK_W-1:0] fresh;
      logic [LINK_W-1:0] prev;
      logic [LINK_W-1:0] next;
      logic [15:0] rest;
      int steps;
      fresh = spare_head;
      prev = NULL_LINK;
      next = busy_head;
      rest = delay;
      steps = 0;
      if (fresh >= NUM_ENTRIES) begin
         due(KIND_OVERFLOW, 16'd0, 1'b1);
         return;
      end
      spare_head = pool_link[fresh[IDX_W-1:0]];
      pool_handle[fresh[IDX_W-1:0]] = tag;
      // equal delays go in front of the existing entry
      while (next < NUM_ENTRIES && steps < NUM_ENTRIES &&
             pool_delta[next[IDX_W-1:0]] < rest) begin
         rest = rest - pool_delta[next[IDX_W-1:0]];
         prev = next;
         next = pool_link[next[IDX_W-1:0]];
         steps++;
      end
      if (next >= NUM_ENTRIES)
         next = NULL_LINK;
      if (prev < NUM_ENTRIES)
         pool_link[prev[IDX_W-1:0]] = fresh;
      else
         busy_head = fresh;
      pool_link[fresh[IDX_W-1:0]] = next;
      pool_delta[fresh[IDX_W-1:0]] = rest;
      if (next < NUM_ENTRIES)
         pool_delta[next[IDX_W-1:0]] = pool_delta[next[IDX_W-1:0]] - rest;
      due(KIND_INSERTED, 16'd0, 1'b1);
   endtask

   task automatic service_expired();
      logic [LINK_W-1:0] p;
      int popped;
      popped = 0;
      if (!hold_flag) begin
         while (popped < NUM_ENTRIES) begin
            p = busy_head;
            if (p >= NUM_ENTRIES || pool_delta[p[IDX_W-1:0]] > 0)
               break;
            busy_head = pool_link[p[IDX_W-1:0]];
            pool_link[p[IDX_W-1:0]] = spare_head;
            spare_head = p;
            due(KIND_EXPIRED, pool_handle[p[IDX_W-1:0]], 1'b0);
            popped++;
         end
      end
      if (popped == 0)
         due(KIND_NONE, 16'd0, 1'b1);
      else
         rsp_due[rsp_due.size() - 1].last = 1'b1;
   endtask

   task automatic note_mismatch(input string what, input int want, input int got);
      mismatches++;
      if (mismatches <= REPORT_MAX)
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
   endtask

   task automatic queue_req(input logic [1:0] op, input logic [15:0] delay,
                            input logic [15:0] tag);
      timer_req_type r;
      r.op = op;
      r.delay = delay;
      r.tag = tag;
      req_backlog.push_back(r);
      req_issued++;
   endtask

   function automatic logic [15:0] pick_delay();
      int r;
      r = $urandom_range(99);
      if (r < 55)
         return 16'($urandom_range(6));
      if (r < 85)
         return 16'($urandom_range(40));
      if (r < 96)
         return 16'($urandom_range(100));
      return 16'($urandom_range(65535));
   endfunction

   task automatic queue_random(input int count, input int ins_pct, input int tick_pct,
                               input int svc_pct);
      int r;
      repeat (count) begin
         r = $urandom_range(99);
         if (r < ins_pct)
            queue_req(FUNC_INSERT, pick_delay(), 16'($urandom_range(65535)));
         else if (r < ins_pct + tick_pct)
            queue_req(FUNC_TICK, 16'($urandom_range(65535)), 16'($urandom_range(65535)));
         else if (r < ins_pct + tick_pct + svc_pct)
            queue_req(FUNC_SERVICE, 16'($urandom_range(65535)), 16'($urandom_range(65535)));
         else
            queue_req(FUNC_UNUSED, 16'($urandom_range(65535)), 16'($urandom_range(65535)));
      end
   endtask

   task automatic drain();
      while (!(req_taken == req_issued && rsp_due.size() == 0))
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_hold(input logic value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      hold_flag = value;
   endtask

   task automatic run_phase(input logic hold, input int send_pct, input int recv_pct,
                            input int count, input int ins_pct, input int tick_pct,
                            input int svc_pct);
      drain();
      write_hold(hold);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      queue_random(count, ins_pct, tick_pct, svc_pct);
   endtask

   // request driver
   always @(posedge clock) begin : req_driver
      timer_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               FUNC_TICK:    tick_timers();
               FUNC_INSERT:  insert_timer(req_tdata[15:0], req_tdata[31:16]);
               FUNC_SERVICE: service_expired();
               default:      ;
            endcase
            req_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_backlog.size() > 0 &&
                (calm_left != 0 || $urandom_range(99) >= send_idle_pct)) begin
               nxt = req_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= nxt.op;
               req_tdata <= {nxt.tag, nxt.delay};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // stretches with no idling on either side
   always @(posedge clock) begin
      if (calm_left > 0)
         calm_left <= calm_left - 1;
      else if ($urandom_range(49) == 0)
         calm_left <= $urandom_range(40, 10);
   end

   always @(posedge clock) begin
      rsp_tready <= (calm_left != 0) || ($urandom_range(99) >= recv_stall_pct);
   end

   // response monitor
   always @(posedge clock) begin : rsp_monitor
      timer_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rsp_due.size() == 0) begin
            note_mismatch("unexpected response kind", 0, rsp_tuser);
         end else begin
            want = rsp_due.pop_front();
            if (rsp_tuser !== want.kind)
               note_mismatch("kind", want.kind, rsp_tuser);
            if (rsp_tdata !== want.handle)
               note_mismatch("expired_handle", want.handle, rsp_tdata);
            if (rsp_tlast !== want.last)
               note_mismatch("last", want.last, rsp_tlast);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         pool_delta[i] = '0;
         pool_handle[i] = '0;
         pool_link[i] = LINK_W'(i + 1);
      end
      busy_head = NULL_LINK;
      spare_head = '0;
      hold_flag = 1'b0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      write_hold(1'b0);
      // empty list on tick and service, unknown op
      queue_req(FUNC_TICK, 16'hffff, 16'hffff);
      queue_req(FUNC_SERVICE, 16'h0000, 16'h0000);
      queue_req(FUNC_UNUSED, 16'hffff, 16'hffff);
      queue_req(FUNC_INSERT, 16'd0, 16'h0000);
      queue_req(FUNC_INSERT, 16'hffff, 16'hffff);
      queue_req(FUNC_INSERT, 16'd5, 16'h1111);
      // equal delays
      queue_req(FUNC_INSERT, 16'd5, 16'h2222);
      queue_req(FUNC_INSERT, 16'd3, 16'h3333);
      queue_req(FUNC_INSERT, 16'd0, 16'haaaa);
      queue_req(FUNC_SERVICE, 16'h5555, 16'haaaa);
      repeat (3) queue_req(FUNC_TICK, 16'd0, 16'd0);
      queue_req(FUNC_SERVICE, 16'd0, 16'd0);
      repeat (2) queue_req(FUNC_TICK, 16'd0, 16'd0);
      queue_req(FUNC_SERVICE, 16'd0, 16'd0);
      queue_req(FUNC_TICK, 16'd0, 16'd0);
      queue_req(FUNC_SERVICE, 16'd0, 16'd0);

      run_phase(1'b0, 0, 0, 90, 45, 30, 23);
      // held expiry lets the pool fill up
      run_phase(1'b1, 69, 0, 60, 70, 15, 13);
      run_phase(1'b0, 0, 69, 90, 30, 40, 28);
      run_phase(1'b0, 13, 13, 100, 45, 30, 23);
      run_phase(1'b1, 0, 0, 30, 50, 25, 23);
      run_phase(1'b0, 13, 13, 40, 20, 45, 33);
      drain();

      if (mismatches == 0 && rsp_due.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

/* delta_list_timer_queue_top.f */
+incdir+hdl
hdl/dltq_pkg.sv
hdl/dltq_store.sv
hdl/delta_list_timer_queue_top.sv
hdl/dltq_checker.sv
test/tb_top.sv
